// ===== src/prefix_expression_stack_evaluator_defines.svh =====
// Assertion macros used by the evaluator's top-level RTL file.
`ifndef PREFIX_EXPRESSION_STACK_EVALUATOR_DEFINES_SVH
`define PREFIX_EXPRESSION_STACK_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PESE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PESE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PESE_ASSERT_IMP(lbl, ante, cons)
`define PESE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/pese_pkg.sv =====
// Shared constants and types of the prefix expression stack evaluator.
package pese_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_TIMES  = 8'd42;
    localparam logic [7:0] CH_DIVIDE = 8'd47;
    localparam logic [7:0] CH_ZERO   = 8'd48;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_LEFTOVER  = 3'd4
    } t_status;

    typedef struct packed {
        t_op               op;
        logic signed [8:0] operand;
        logic              last;
    } t_tok;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

// ===== src/pese_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pese_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pese_front.sv =====
// Front end: accepts characters, classifies them and queues the decoded tokens.
module pese_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    i_token_char,
    input  logic          i_last_token,
    output logic          o_head_valid,
    output pese_pkg::t_tok o_head,
    input  logic          i_head_take
);

    pese_pkg::t_tok                  r_mem [pese_pkg::QUEUE_DEPTH];
    logic [pese_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [pese_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [pese_pkg::QUEUE_AW:0]     r_fill;
    pese_pkg::t_tok                  w_tok;
    logic                            w_wr;
    logic                            w_rd;

    always_comb begin
        w_tok.operand = $signed({1'b0, i_token_char}) - $signed({1'b0, pese_pkg::CH_ZERO});
        w_tok.last    = i_last_token;
        unique case (i_token_char)
            pese_pkg::CH_PLUS:   w_tok.op = pese_pkg::OP_ADD;
            pese_pkg::CH_MINUS:  w_tok.op = pese_pkg::OP_SUB;
            pese_pkg::CH_TIMES:  w_tok.op = pese_pkg::OP_MUL;
            pese_pkg::CH_DIVIDE: w_tok.op = pese_pkg::OP_DIV;
            default:             w_tok.op = pese_pkg::OP_PUSH;
        endcase
    end

    assign full         = (r_fill == (pese_pkg::QUEUE_AW + 1)'(pese_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_fill != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_wr         = push && !full;
    assign w_rd         = i_head_take && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == pese_pkg::QUEUE_AW'(pese_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == pese_pkg::QUEUE_AW'(pese_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ===== src/pese_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pese_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pese_pkg::t_div_req i_req,
    output pese_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg;
    logic [32:0] w_rem_sh;
    logic [32:0] w_diff;
    logic [31:0] w_abs_x;
    logic [31:0] w_abs_y;

    assign w_abs_x  = i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
    assign w_abs_y  = i_req.divisor[31] ? (32'd0 - i_req.divisor) : i_req.divisor;
    assign w_rem_sh = {r_rem, r_quo[31]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (32'd0 - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= w_abs_x;
                r_dvs  <= w_abs_y;
                r_neg  <= i_req.dividend[31] ^ i_req.divisor[31];
            end else if (r_busy) begin
                if (!w_diff[32]) begin
                    r_rem <= w_diff[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/pese_back.sv =====
// Back end: executes queued tokens on the value stack and holds the result word.
module pese_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  pese_pkg::t_tok     i_head,
    output logic               o_head_take,
    output pese_pkg::t_div_req o_div_req,
    input  pese_pkg::t_div_rsp i_div_rsp,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_result_value,
    output logic [2:0]         o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_OPER,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [pese_pkg::COUNT_W-1:0]    r_count;
    pese_pkg::t_status               r_err;
    logic [31:0]                     r_tos;
    pese_pkg::t_op                   r_op;
    logic                            r_last;
    logic                            r_out_valid;
    logic [31:0]                     r_out_value;
    pese_pkg::t_status               r_out_status;

    logic                            w_take;
    logic                            w_push_ok;
    logic                            w_we;
    logic [pese_pkg::COUNT_W-1:0]    w_cnt_m1;
    logic [pese_pkg::COUNT_W-1:0]    w_cnt_m2;
    logic [31:0]                     w_y;
    logic [31:0]                     w_prod;
    logic [31:0]                     w_operand;
    pese_pkg::t_status               w_status;
    t_state                          w_after;

    assign w_take = (r_state == S_IDLE) && i_head_valid
                    && (!i_head.last || !r_out_valid || pop);
    assign o_head_take = w_take;

    assign w_operand = 32'(i_head.operand);
    assign w_push_ok = w_take && (r_err == pese_pkg::ST_OK) && (i_head.op == pese_pkg::OP_PUSH)
                       && (r_count < pese_pkg::COUNT_W'(pese_pkg::STACK_DEPTH));
    assign w_we      = w_push_ok && (r_count != '0);
    assign w_cnt_m1  = r_count - pese_pkg::COUNT_W'(1);
    assign w_cnt_m2  = r_count - pese_pkg::COUNT_W'(2);
    assign w_prod    = r_tos * w_y;

    pese_ram #(
        .WIDTH (32),
        .DEPTH (pese_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_cnt_m1[pese_pkg::STACK_AW-1:0]),
        .i_wdata (r_tos),
        .i_raddr (w_cnt_m2[pese_pkg::STACK_AW-1:0]),
        .o_rdata (w_y)
    );

    assign o_div_req.start    = (r_state == S_OPER) && (r_op == pese_pkg::OP_DIV) && (w_y != '0);
    assign o_div_req.dividend = r_tos;
    assign o_div_req.divisor  = w_y;

    always_comb begin
        if (r_err != pese_pkg::ST_OK) begin
            w_status = r_err;
        end else if (r_count == '0) begin
            w_status = pese_pkg::ST_UNDERFLOW;
        end else if (r_count != pese_pkg::COUNT_W'(1)) begin
            w_status = pese_pkg::ST_LEFTOVER;
        end else begin
            w_status = pese_pkg::ST_OK;
        end
    end

    assign w_after = r_last ? S_EMIT : S_IDLE;

    assign empty          = !r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= pese_pkg::ST_OK;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_last <= i_head.last;
                        r_op   <= i_head.op;
                        if (r_err != pese_pkg::ST_OK) begin
                            r_state <= i_head.last ? S_EMIT : S_IDLE;
                        end else if (i_head.op == pese_pkg::OP_PUSH) begin
                            if (w_push_ok) begin
                                r_tos   <= w_operand;
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_err <= pese_pkg::ST_OVERFLOW;
                            end
                            r_state <= i_head.last ? S_EMIT : S_IDLE;
                        end else if (r_count < pese_pkg::COUNT_W'(2)) begin
                            r_err   <= pese_pkg::ST_UNDERFLOW;
                            r_state <= i_head.last ? S_EMIT : S_IDLE;
                        end else begin
                            r_state <= S_OPER;
                        end
                    end
                end
                S_OPER: begin
                    case (r_op)
                        pese_pkg::OP_ADD: begin
                            r_tos   <= r_tos + w_y;
                            r_count <= w_cnt_m1;
                            r_state <= w_after;
                        end
                        pese_pkg::OP_SUB: begin
                            r_tos   <= r_tos - w_y;
                            r_count <= w_cnt_m1;
                            r_state <= w_after;
                        end
                        pese_pkg::OP_MUL: begin
                            r_tos   <= w_prod;
                            r_count <= w_cnt_m1;
                            r_state <= w_after;
                        end
                        pese_pkg::OP_DIV: begin
                            if (w_y == '0) begin
                                r_err   <= pese_pkg::ST_DIVZERO;
                                r_count <= w_cnt_m2;
                                r_state <= w_after;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        default: begin
                            r_state <= w_after;
                        end
                    endcase
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_tos   <= i_div_rsp.quotient;
                        r_count <= w_cnt_m1;
                        r_state <= w_after;
                    end
                end
                S_EMIT: begin
                    r_out_valid  <= 1'b1;
                    r_out_status <= w_status;
                    r_out_value  <= (w_status == pese_pkg::ST_OK) ? r_tos : 32'd0;
                    r_count      <= '0;
                    r_err        <= pese_pkg::ST_OK;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/prefix_expression_stack_evaluator.sv =====
// Top level of the prefix expression stack evaluator.
//
//  Channel  Direction  Handshake        Words
//  tokens   in         push / full      i_token_char, i_last_token
//  results  out        pop / empty      o_result_value, o_status
//
// An operand character is done in the idle state; '+', '-' and '*' also pass
// through the operate state (one stack memory read), '/' waits for the 32-step
// divider. The final character goes on to the emit state to form the result word.
// Reset is synchronous and active low; the stack needs no clearing pass.
// A four-entry token queue lets the input side run ahead of the back end,
// and the result register lets work continue while a result waits for pop.
`include "prefix_expression_stack_evaluator_defines.svh"

module prefix_expression_stack_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_token_char,
    input  logic               i_last_token,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_result_value,
    output logic [2:0]         o_status
);

    logic               w_head_valid;
    pese_pkg::t_tok     w_head;
    logic               w_head_take;
    pese_pkg::t_div_req w_div_req;
    pese_pkg::t_div_rsp w_div_rsp;

    pese_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_token_char (i_token_char),
        .i_last_token (i_last_token),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_head_take  (w_head_take)
    );

    pese_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    pese_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .o_head_take    (w_head_take),
        .o_div_req      (w_div_req),
        .i_div_rsp      (w_div_rsp),
        .empty          (empty),
        .pop            (pop),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    `PESE_ASSERT_IMP(a_take_nonempty, w_head_take, w_head_valid)
    `PESE_ASSERT_NXT(a_div_no_early_done, w_div_req.start, !w_div_rsp.done)
    `PESE_ASSERT_IMP(a_div_start_quiet, w_div_rsp.done, !w_div_req.start)
    `PESE_ASSERT_IMP(a_error_zero_value, !empty && (o_status != pese_pkg::ST_OK), o_result_value == 32'sd0)

endmodule
